// ===== rtl/srb_pkg.sv =====
package srb_pkg;

  // Golden-ratio step and the two finaliser multipliers of SplitMix64.
  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] FINAL_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] FINAL_MUL_B = 64'h94D0_49BB_1331_11EB;

  // Number of quotient bits the remainder unit resolves, one per cycle.
  localparam int unsigned REM_BITS = 32;

  // Request kinds carried on the action field.
  localparam logic [1:0] ACT_RESEED = 2'd0;
  localparam logic [1:0] ACT_RAW    = 2'd1;
  localparam logic [1:0] ACT_BELOW  = 2'd2;
  localparam logic [1:0] ACT_RANGE  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_MATCH_SEED     = 2'd0;
  localparam logic [1:0] REG_SLOT_NUMBER    = 2'd1;
  localparam logic [1:0] REG_PROFILE_WORD   = 2'd2;
  localparam logic [1:0] REG_STREAM_PURPOSE = 2'd3;

  // Addend selects for the three multiply-add steps of the seed mix.
  localparam logic [1:0] MIX_SLOT    = 2'd0;
  localparam logic [1:0] MIX_PROFILE = 2'd1;
  localparam logic [1:0] MIX_PURPOSE = 2'd2;

  typedef struct packed {
    logic [63:0] match_seed;
    logic [7:0]  slot_number;
    logic [31:0] profile_word;
    logic [7:0]  stream_purpose;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_GOLD,
    OP_MIX_ADD,
    OP_SEED_SET,
    OP_ADVANCE,
    OP_MUL_A,
    OP_XS27,
    OP_MUL_B,
    OP_XS31,
    OP_RES_RAW,
    OP_REM_THR,
    OP_THR_SET,
    OP_REM_D,
    OP_RES_BELOW,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] mix_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       degen;
    logic       mul_done;
    logic       rem_done;
    logic       reject;
    logic       out_free;
  } sts_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_LL,
    MP_LH,
    MP_HL,
    MP_ADD
  } mul_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MIX_MUL,
    S_MIX_WAIT,
    S_MIX_END,
    S_THR,
    S_THR_WAIT,
    S_DRAW_ADV,
    S_DRAW_MA,
    S_DRAW_WA,
    S_DRAW_MB,
    S_DRAW_WB,
    S_DRAW_CHK,
    S_REM_WAIT,
    S_FINISH
  } ctrl_state_t;

endpackage

// ===== rtl/splitmix_bounded_random_core.sv =====
// SplitMix64 random source with unbiased bounded draws. Each request on the
// in_ channel yields exactly one result on the out_ channel, and requests are
// handled one at a time: the input side takes a new request from the same
// cycle in which the previous result is first presented. Every 64-bit multiply
// runs as a start step, then three 32x32 partial products on one shared
// multiplier, an add and a hand-over. One generator draw is an advance, the
// two finaliser multiplies and a check; a raw request makes one draw, and a
// reseed runs its three multiply-add steps. A below or range request first
// works out the rejection threshold on the bit-serial remainder unit, then
// makes one draw and a fresh draw for every draw that is rejected, and takes
// the final remainder on the same unit. A below request with a zero bound,
// or a range request whose high end is not above its low end or whose span
// covers all 2^32 values, goes straight to its result without touching the
// generator state. A stalled result holds the next one back until it has
// been taken. The configuration registers sit on an APB-style port at byte
// addresses 0, 8, 16 and 24 and should only be written while no request is
// in flight.

module splitmix_bounded_random_core (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_bound,
  input  logic signed [31:0] in_range_low,
  input  logic signed [31:0] in_range_high,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] out_value,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  // Configuration registers. Registers are 64-bit aligned, so the register
  // index is taken from address bits 4 and 3.
  srb_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // Control and status between the sequencer and the datapath.
  srb_pkg::cmd_t cmd;
  srb_pkg::sts_t status;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        srb_pkg::REG_MATCH_SEED:     cfg_r.match_seed     <= pwdata;
        srb_pkg::REG_SLOT_NUMBER:    cfg_r.slot_number    <= pwdata[7:0];
        srb_pkg::REG_PROFILE_WORD:   cfg_r.profile_word   <= pwdata[31:0];
        srb_pkg::REG_STREAM_PURPOSE: cfg_r.stream_purpose <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data is combinational from the address; narrower registers read
  // back zero-extended.
  always_comb begin
    case (cfg_idx)
      srb_pkg::REG_MATCH_SEED:     prdata = cfg_r.match_seed;
      srb_pkg::REG_SLOT_NUMBER:    prdata = 64'(cfg_r.slot_number);
      srb_pkg::REG_PROFILE_WORD:   prdata = 64'(cfg_r.profile_word);
      srb_pkg::REG_STREAM_PURPOSE: prdata = 64'(cfg_r.stream_purpose);
      default:                     prdata = '0;
    endcase
  end

  // The sequencer walks each request through the seed mix, the finaliser
  // or the rejection loop, issuing at most one datapath command per cycle.
  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // The datapath holds the generator state, the request operands, the
  // shared multiplier, the remainder unit and the output register.
  srb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_bound      (in_bound),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .status        (status)
  );

  // An accepted request keeps the input side stalled until it has finished.
  a_stall_after_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input not stalled after a request was accepted");

  // A new result only appears as a request completes, never while idle.
  a_result_from_request : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result raised without a request in flight");

  // The input side only reopens together with the hand-over of a result.
  a_reopen_with_result : assert property (
    @(posedge clk) disable iff (!rst_n)
    ($past(in_stall) && !in_stall && $past(rst_n)) |-> out_valid
  ) else $error("input reopened without a result being presented");

endmodule

// ===== rtl/srb_mul64.sv =====
module srb_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] product
);

  // Low 64 bits of a 64x64 product from three 32x32 partial products.
  srb_pkg::mul_phase_t phase_r;
  logic                done_r;
  logic [63:0]         a_r;
  logic [63:0]         b_r;
  logic [63:0]         part_r;
  logic [63:0]         acc_r;
  logic [31:0]         fa;
  logic [31:0]         fb;
  logic [63:0]         part_nxt;

  always_comb begin
    case (phase_r)
      srb_pkg::MP_LL: begin
        fa = a_r[31:0];
        fb = b_r[31:0];
      end
      srb_pkg::MP_LH: begin
        fa = a_r[31:0];
        fb = b_r[63:32];
      end
      srb_pkg::MP_HL: begin
        fa = a_r[63:32];
        fb = b_r[31:0];
      end
      default: begin
        fa = '0;
        fb = '0;
      end
    endcase
    part_nxt = 64'(fa) * 64'(fb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srb_pkg::MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        srb_pkg::MP_IDLE: if (start) phase_r <= srb_pkg::MP_LL;
        srb_pkg::MP_LL:   phase_r <= srb_pkg::MP_LH;
        srb_pkg::MP_LH:   phase_r <= srb_pkg::MP_HL;
        srb_pkg::MP_HL:   phase_r <= srb_pkg::MP_ADD;
        srb_pkg::MP_ADD: begin
          phase_r <= srb_pkg::MP_IDLE;
          done_r  <= 1'b1;
        end
        default: phase_r <= srb_pkg::MP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      srb_pkg::MP_IDLE: begin
        if (start) begin
          a_r <= op_a;
          b_r <= op_b;
        end
      end
      srb_pkg::MP_LL: part_r <= part_nxt;
      srb_pkg::MP_LH: begin
        acc_r  <= part_r;
        part_r <= part_nxt;
      end
      srb_pkg::MP_HL: begin
        acc_r[63:32] <= acc_r[63:32] + part_r[31:0];
        part_r       <= part_nxt;
      end
      srb_pkg::MP_ADD: acc_r[63:32] <= acc_r[63:32] + part_r[31:0];
      default: ;
    endcase
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/srb_rem32.sv =====
module srb_rem32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  // Restoring remainder, one dividend bit per cycle.
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] dvd_r;
  logic [31:0] dsr_r;
  logic [31:0] rem_r;
  logic [32:0] shifted;
  logic [32:0] trial;

  always_comb begin
    shifted = {rem_r, dvd_r[31]};
    trial   = shifted - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(srb_pkg::REM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= trial[32] ? shifted[31:0] : trial[31:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/srb_datapath.sv =====
module srb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  srb_pkg::cfg_t       cfg,
  input  srb_pkg::cmd_t       cmd,
  input  logic [1:0]          in_action,
  input  logic [31:0]         in_bound,
  input  logic signed [31:0]  in_range_low,
  input  logic signed [31:0]  in_range_high,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [32:0]  out_value,
  output srb_pkg::sts_t       status
);

  logic [63:0] state_r;
  logic        out_valid_r;
  logic [32:0] out_value_r;
  logic [63:0] z_r;
  logic [31:0] bnd_r;
  logic [31:0] low_r;
  logic [31:0] thr_r;
  logic [31:0] d_r;
  logic [32:0] result_r;
  logic [1:0]  action_r;
  logic        range_r;
  logic        degen_r;

  logic        mul_start;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] product;
  logic        rem_start;
  logic [31:0] rem_dvd;
  logic        rem_done;
  logic [31:0] rem_value;

  logic        is_range;
  logic [31:0] span;
  logic [31:0] eff_bound;
  logic        hi_le_lo;
  logic [63:0] addend;
  logic [63:0] adv;
  logic [63:0] xs27;
  logic [63:0] xs31;
  logic [31:0] below_sum;

  always_comb begin
    is_range  = (in_action == srb_pkg::ACT_RANGE);
    span      = $unsigned(in_range_high) - $unsigned(in_range_low) + 32'd1;
    hi_le_lo  = (in_range_high <= in_range_low);
    eff_bound = is_range ? span : in_bound;
    case (cmd.mix_sel)
      srb_pkg::MIX_SLOT:    addend = 64'(cfg.slot_number);
      srb_pkg::MIX_PROFILE: addend = 64'(cfg.profile_word);
      srb_pkg::MIX_PURPOSE: addend = 64'(cfg.stream_purpose);
      default:              addend = '0;
    endcase
    adv       = state_r + srb_pkg::GOLDEN_STEP;
    xs27      = product ^ (product >> 27);
    xs31      = product ^ (product >> 31);
    below_sum = low_r + rem_value;
    case (cmd.op)
      srb_pkg::OP_MUL_A: mul_b = srb_pkg::FINAL_MUL_A;
      srb_pkg::OP_MUL_B: mul_b = srb_pkg::FINAL_MUL_B;
      default:           mul_b = srb_pkg::GOLDEN_STEP;
    endcase
    mul_start = (cmd.op == srb_pkg::OP_MUL_GOLD) || (cmd.op == srb_pkg::OP_MUL_A) ||
                (cmd.op == srb_pkg::OP_MUL_B);
    rem_start = (cmd.op == srb_pkg::OP_REM_THR) || (cmd.op == srb_pkg::OP_REM_D);
    // The rejection threshold 2^32 mod b equals (2^32 - b) mod b, which fits 32 bits.
    rem_dvd   = (cmd.op == srb_pkg::OP_REM_THR) ? (32'd0 - bnd_r) : d_r;
  end

  srb_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (z_r),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (product)
  );

  srb_rem32 u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_dvd),
    .divisor   (bnd_r),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srb_pkg::GOLDEN_STEP;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == srb_pkg::OP_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == srb_pkg::OP_SEED_SET) begin
        state_r <= (z_r == 64'd0) ? srb_pkg::GOLDEN_STEP : z_r;
      end else if (cmd.op == srb_pkg::OP_ADVANCE) begin
        state_r <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      srb_pkg::OP_LOAD: begin
        action_r <= in_action;
        range_r  <= is_range;
        bnd_r    <= eff_bound;
        low_r    <= is_range ? $unsigned(in_range_low) : 32'd0;
        degen_r  <= (eff_bound == 32'd0) || (is_range && hi_le_lo);
        result_r <= is_range ? {in_range_low[31], $unsigned(in_range_low)} : 33'd0;
        z_r      <= cfg.match_seed;
      end
      srb_pkg::OP_MIX_ADD:   z_r      <= product + addend;
      srb_pkg::OP_ADVANCE:   z_r      <= adv ^ (adv >> 30);
      srb_pkg::OP_XS27:      z_r      <= xs27;
      srb_pkg::OP_XS31:      d_r      <= xs31[63:32];
      srb_pkg::OP_RES_RAW:   result_r <= {1'b0, d_r};
      srb_pkg::OP_THR_SET:   thr_r    <= rem_value;
      srb_pkg::OP_RES_BELOW: result_r <= {range_r & below_sum[31], below_sum};
      srb_pkg::OP_PUBLISH:   out_value_r <= result_r;
      default: ;
    endcase
  end

  always_comb begin
    status.action   = action_r;
    status.degen    = degen_r;
    status.mul_done = mul_done;
    status.rem_done = rem_done;
    status.reject   = (d_r < thr_r);
    status.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);

endmodule

// ===== rtl/srb_ctrl.sv =====
module srb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  srb_pkg::sts_t status,
  output logic          in_stall,
  output srb_pkg::cmd_t cmd
);

  srb_pkg::ctrl_state_t state_r;
  srb_pkg::ctrl_state_t state_nxt;
  logic [1:0]           mix_cnt_r;
  logic [1:0]           mix_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= srb_pkg::S_IDLE;
      mix_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mix_cnt_r <= mix_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mix_cnt_nxt = mix_cnt_r;
    cmd.op      = srb_pkg::OP_NONE;
    cmd.mix_sel = mix_cnt_r;
    in_stall    = 1'b1;
    case (state_r)
      srb_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = srb_pkg::OP_LOAD;
          state_nxt = srb_pkg::S_DISPATCH;
        end
      end
      srb_pkg::S_DISPATCH: begin
        case (status.action)
          srb_pkg::ACT_RESEED: begin
            mix_cnt_nxt = srb_pkg::MIX_SLOT;
            state_nxt   = srb_pkg::S_MIX_MUL;
          end
          srb_pkg::ACT_RAW: state_nxt = srb_pkg::S_DRAW_ADV;
          default: state_nxt = status.degen ? srb_pkg::S_FINISH : srb_pkg::S_THR;
        endcase
      end
      srb_pkg::S_MIX_MUL: begin
        cmd.op    = srb_pkg::OP_MUL_GOLD;
        state_nxt = srb_pkg::S_MIX_WAIT;
      end
      srb_pkg::S_MIX_WAIT: begin
        if (status.mul_done) begin
          cmd.op = srb_pkg::OP_MIX_ADD;
          if (mix_cnt_r == srb_pkg::MIX_PURPOSE) begin
            state_nxt = srb_pkg::S_MIX_END;
          end else begin
            mix_cnt_nxt = mix_cnt_r + 2'd1;
            state_nxt   = srb_pkg::S_MIX_MUL;
          end
        end
      end
      srb_pkg::S_MIX_END: begin
        cmd.op    = srb_pkg::OP_SEED_SET;
        state_nxt = srb_pkg::S_FINISH;
      end
      srb_pkg::S_THR: begin
        cmd.op    = srb_pkg::OP_REM_THR;
        state_nxt = srb_pkg::S_THR_WAIT;
      end
      srb_pkg::S_THR_WAIT: begin
        if (status.rem_done) begin
          cmd.op    = srb_pkg::OP_THR_SET;
          state_nxt = srb_pkg::S_DRAW_ADV;
        end
      end
      srb_pkg::S_DRAW_ADV: begin
        cmd.op    = srb_pkg::OP_ADVANCE;
        state_nxt = srb_pkg::S_DRAW_MA;
      end
      srb_pkg::S_DRAW_MA: begin
        cmd.op    = srb_pkg::OP_MUL_A;
        state_nxt = srb_pkg::S_DRAW_WA;
      end
      srb_pkg::S_DRAW_WA: begin
        if (status.mul_done) begin
          cmd.op    = srb_pkg::OP_XS27;
          state_nxt = srb_pkg::S_DRAW_MB;
        end
      end
      srb_pkg::S_DRAW_MB: begin
        cmd.op    = srb_pkg::OP_MUL_B;
        state_nxt = srb_pkg::S_DRAW_WB;
      end
      srb_pkg::S_DRAW_WB: begin
        if (status.mul_done) begin
          cmd.op    = srb_pkg::OP_XS31;
          state_nxt = srb_pkg::S_DRAW_CHK;
        end
      end
      srb_pkg::S_DRAW_CHK: begin
        if (status.action == srb_pkg::ACT_RAW) begin
          cmd.op    = srb_pkg::OP_RES_RAW;
          state_nxt = srb_pkg::S_FINISH;
        end else if (status.reject) begin
          state_nxt = srb_pkg::S_DRAW_ADV;
        end else begin
          cmd.op    = srb_pkg::OP_REM_D;
          state_nxt = srb_pkg::S_REM_WAIT;
        end
      end
      srb_pkg::S_REM_WAIT: begin
        if (status.rem_done) begin
          cmd.op    = srb_pkg::OP_RES_BELOW;
          state_nxt = srb_pkg::S_FINISH;
        end
      end
      srb_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.op    = srb_pkg::OP_PUBLISH;
          state_nxt = srb_pkg::S_IDLE;
        end
      end
      default: state_nxt = srb_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== verif/splitmix_bounded_random_core_tb.sv =====
module splitmix_bounded_random_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The long receiver hold-off is the longest quiet stretch by design, so the
  // watchdog sits well clear of it and of a single request, even with a run of
  // rejected draws.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 100;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 116;
  localparam int DIRECTED_ROWS   = 23;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] bound;
    logic [31:0] low;
    logic [31:0] high;
  } request_t;

  // A directed row either carries its expected value, where it is obvious, or
  // leaves the value to the predictor.
  typedef struct packed {
    request_t    req;
    logic        typed;
    logic [32:0] value;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = srb_pkg::ACT_RESEED;
  logic [31:0]        in_bound = '0;
  logic signed [31:0] in_range_low = '0;
  logic signed [31:0] in_range_high = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [32:0] out_value;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  splitmix_bounded_random_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_bound      (in_bound),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the configuration registers and of the generator state.
  // The generator resets to the golden step, which is what mixing an all-zero
  // configuration yields.
  logic [63:0] seed_reg = '0;
  logic [7:0]  slot_reg = '0;
  logic [31:0] profile_reg = '0;
  logic [7:0]  purpose_reg = '0;
  logic [63:0] gen_state = srb_pkg::GOLDEN_STEP;

  // Values still owed by the block, oldest first.
  logic [32:0] expected_values [$];

  int errors = 0;
  int results_checked = 0;
  int settings_used = 1;
  int action_count [4] = '{0, 0, 0, 0};

  // Set by the stimulus to switch off idling on both sides for a stretch, and
  // to ask the receiver for one long hold-off.
  bit quiet = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_wait = 0;
  int idle_cycles = 0;

  // One SplitMix64 step: advance the state by the golden step, then run the
  // finaliser and keep the upper half.
  function automatic logic [31:0] next_raw_word();
    logic [63:0] z;
    gen_state = gen_state + srb_pkg::GOLDEN_STEP;
    z = gen_state;
    z = (z ^ (z >> 30)) * srb_pkg::FINAL_MUL_A;
    z = (z ^ (z >> 27)) * srb_pkg::FINAL_MUL_B;
    z = z ^ (z >> 31);
    return z[63:32];
  endfunction

  // Unbiased draw in [0, limit). Words below 2^32 mod limit are thrown away so
  // that every remainder is equally likely. A zero limit draws nothing.
  function automatic logic [31:0] uniform_below(logic [31:0] limit);
    logic [63:0] reject_floor;
    logic [31:0] word;
    if (limit == 32'd0)
      return 32'd0;
    reject_floor = 64'h1_0000_0000 % {32'd0, limit};
    do
      word = next_raw_word();
    while ({32'd0, word} < reject_floor);
    return word % limit;
  endfunction

  // Works out the value that a request returns and updates the shadow state.
  function automatic logic [32:0] predict_value(request_t req);
    logic [63:0] mixed;
    logic [31:0] span;
    logic [31:0] drawn;
    case (req.action)
      srb_pkg::ACT_RESEED: begin
        mixed = seed_reg * srb_pkg::GOLDEN_STEP + {56'd0, slot_reg};
        mixed = mixed * srb_pkg::GOLDEN_STEP + {32'd0, profile_reg};
        mixed = mixed * srb_pkg::GOLDEN_STEP + {56'd0, purpose_reg};
        gen_state = (mixed == 64'd0) ? srb_pkg::GOLDEN_STEP : mixed;
        return 33'd0;
      end
      srb_pkg::ACT_RAW:   return {1'b0, next_raw_word()};
      srb_pkg::ACT_BELOW: return {1'b0, uniform_below(req.bound)};
      default: begin
        // A span of all 2^32 values wraps to zero and so draws nothing.
        if ($signed(req.high) <= $signed(req.low)) begin
          drawn = req.low;
        end else begin
          span = req.high - req.low + 32'd1;
          drawn = req.low + uniform_below(span);
        end
        return {drawn[31], drawn};
      end
    endcase
  endfunction

  // Offers one request after a random gap and waits until it is taken. The
  // expectation is queued at the edge that accepts the request.
  task automatic send_request(request_t req, logic typed, logic [32:0] typed_value);
    int gap;
    logic [32:0] predicted;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= req.action;
    in_bound      <= req.bound;
    in_range_low  <= req.low;
    in_range_high <= req.high;
    do
      @(posedge clk);
    while (in_stall);
    predicted = predict_value(req);
    expected_values.push_back(typed ? typed_value : predicted);
    action_count[req.action]++;
  endtask

  // Setup cycle, then the access cycle; the register takes the data at the
  // edge where penable and pready are both high.
  task automatic write_reg(logic [1:0] index, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      srb_pkg::REG_MATCH_SEED:     seed_reg = value;
      srb_pkg::REG_SLOT_NUMBER:    slot_reg = value[7:0];
      srb_pkg::REG_PROFILE_WORD:   profile_reg = value[31:0];
      srb_pkg::REG_STREAM_PURPOSE: purpose_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_until_drained();
    while (expected_values.size() != 0)
      @(posedge clk);
  endtask

  // Mostly well-formed draws, with the bounds and ranges steered towards
  // their awkward corners: zero bounds, tiny bounds, bounds just past 2^31
  // where nearly half of all draws are rejected, inverted and full ranges.
  // Fields that the action ignores are left as random noise.
  function automatic request_t random_request();
    request_t r;
    int pick;
    r.bound = $urandom;
    r.low   = $urandom;
    r.high  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      r.action = srb_pkg::ACT_RESEED;
    else if (pick < 30)
      r.action = srb_pkg::ACT_RAW;
    else if (pick < 65)
      r.action = srb_pkg::ACT_BELOW;
    else
      r.action = srb_pkg::ACT_RANGE;
    pick = $urandom_range(0, 9);
    if (r.action == srb_pkg::ACT_BELOW) begin
      case (pick)
        0:       r.bound = 32'd0;
        1, 2, 3: r.bound = $urandom_range(1, 16);
        4:       r.bound = 32'h8000_0000 + $urandom_range(0, 255);
        5:       r.bound = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: ;
      endcase
    end else if (r.action == srb_pkg::ACT_RANGE) begin
      case (pick)
        0:       r.high = r.low - $urandom_range(0, 3);
        1: begin
          r.low  = 32'h8000_0000;
          r.high = 32'h7FFF_FFFF;
        end
        2, 3, 4: r.high = r.low + $urandom_range(1, 100);
        5: begin
          r.low  = -$urandom_range(0, 50);
          r.high = $urandom_range(0, 50);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Directed requests, run against the reset configuration. The first raw
  // draw and the one after a zero-configuration reseed must agree, since the
  // reseed puts the generator back to its reset state.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{srb_pkg::ACT_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RESEED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, 33'd0},
    '{'{srb_pkg::ACT_RAW,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h0000_0001, 32'h0000_0000, 32'h0000_0000}, 1'b1, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h0000_0002, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h8000_0001, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h0000_0003, 32'h0000_0000, 32'h0000_0000}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h0000_0005, 32'h0000_0005}, 1'b1, 33'd5},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFD}, 1'b1, 33'd7},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
      33'h1_8000_0000},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
      33'h0_7FFF_FFFF},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h8000_0000, 32'h8000_0001}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFF6, 32'h0000_000A}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFE}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFF}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 33'd0},
    '{'{srb_pkg::ACT_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 33'd0},
    '{'{srb_pkg::ACT_BELOW,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 33'd0},
    '{'{srb_pkg::ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000}, 1'b1, 33'd0}
  };

  // Receiver. Each result is compared with the oldest expectation. After
  // every accepted result a fresh number of stall cycles is drawn, and these
  // are spent only while a result is actually waiting, so that back-pressure
  // lands on the block rather than on an empty channel. A long hold-off, when
  // asked for, is counted down here regardless of what the block offers.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_values.size() == 0) begin
        $display("%0t: result %h arrived with no request outstanding", $time, out_value);
        errors++;
      end else if (out_value !== $signed(expected_values[0])) begin
        $display("%0t: value mismatch: expected %h, actual %h", $time,
                 expected_values[0], out_value);
        errors++;
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
      rx_wait = quiet ? 0 : $urandom_range(0, 9);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      if (out_valid && out_stall)
        rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: the run is abandoned once neither channel has moved for too
  // long, which covers a hung block as well as a lost result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, the directed table against the reset configuration,
  // then a series of register settings with random requests under each. The
  // registers are only rewritten once every owed result has been taken.
  initial begin
    int phase;
    int n;
    logic [63:0] seed_value;
    logic [63:0] slot_value;
    logic [63:0] profile_value;
    logic [63:0] purpose_value;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].value);
    in_valid <= 1'b0;
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (phase = 0; phase < PHASES; phase++) begin
      // The first setting is every register at its top value (the narrow
      // registers also see ones above their width), the second is all zero,
      // which makes a reseed land on the golden step; the rest are random.
      case (phase)
        0: begin
          seed_value    = '1;
          slot_value    = '1;
          profile_value = '1;
          purpose_value = '1;
        end
        1: begin
          seed_value    = '0;
          slot_value    = '0;
          profile_value = '0;
          purpose_value = '0;
        end
        default: begin
          seed_value    = {$urandom, $urandom};
          slot_value    = {$urandom, $urandom};
          profile_value = {$urandom, $urandom};
          purpose_value = {$urandom, $urandom};
        end
      endcase
      write_reg(srb_pkg::REG_MATCH_SEED, seed_value);
      write_reg(srb_pkg::REG_SLOT_NUMBER, slot_value);
      write_reg(srb_pkg::REG_PROFILE_WORD, profile_value);
      write_reg(srb_pkg::REG_STREAM_PURPOSE, purpose_value);
      settings_used++;

      // One phase runs with no idling on either side.
      quiet = (phase == 3);
      // Start each phase from the new setting so that it shapes the draws.
      send_request('{srb_pkg::ACT_RESEED, $urandom, $urandom, $urandom}, 1'b0, 33'd0);
      for (n = 1; n < ITEMS_PER_PHASE; n++) begin
        // Part way through one phase the receiver stops taking results for a
        // long stretch while requests keep coming, so the block backs up and
        // stalls its input.
        if (phase == 2 && n == 20)
          hold_requests++;
        send_request(random_request(), 1'b0, 33'd0);
      end
      in_valid <= 1'b0;
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    // Anything the block produces from here on has no expectation and is
    // flagged by the receiver.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d reseeds, %0d raw, %0d below and %0d range requests",
             action_count[srb_pkg::ACT_RESEED], action_count[srb_pkg::ACT_RAW],
             action_count[srb_pkg::ACT_BELOW], action_count[srb_pkg::ACT_RANGE]);
    $display("under %0d register settings; %0d results checked, %0d mismatches.",
             settings_used, results_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srb_pkg.sv
rtl/srb_mul64.sv
rtl/srb_rem32.sv
rtl/srb_datapath.sv
rtl/srb_ctrl.sv
rtl/splitmix_bounded_random_core.sv
verif/splitmix_bounded_random_core_tb.sv
